@@ rtl/mqttd_pkg.sv @@
// shared types and constants for the mqtt packet deframer
package mqttd_pkg;

  // parser phase of the front end
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  // event codes of a result record
  typedef enum logic [2:0] {
    EV_CONNECTED = 3'd0,
    EV_REFUSED   = 3'd1,
    EV_SUBACK    = 3'd2,
    EV_PUBLISH   = 3'd3,
    EV_PUBACK    = 3'd4,
    EV_UNHANDLED = 3'd5,
    EV_MALFORMED = 3'd6
  } event_t;

  // control packet types
  localparam logic [3:0] PT_CONNACK  = 4'h2;
  localparam logic [3:0] PT_PUBLISH  = 4'h3;
  localparam logic [3:0] PT_PUBACK   = 4'h4;
  localparam logic [3:0] PT_PUBREC   = 4'h5;
  localparam logic [3:0] PT_SUBACK   = 4'h9;
  localparam logic [3:0] PT_UNSUBACK = 4'hB;

  // result kinds
  localparam logic KIND_EVENT = 1'b0;
  localparam logic KIND_ACK   = 1'b1;

  // remaining length byte of a puback or pubrec reply
  localparam logic [7:0] ACK_LEN_BYTE = 8'h02;

  localparam int unsigned LEN_W = 28;
  localparam int unsigned TDATA_W = 88;

  // packet completion handed from front to back
  typedef struct packed {
    logic              too_long;
    logic [7:0]        header;
    logic [LEN_W-1:0]  rem_len;
    logic [15:0]       first_word;
    logic [7:0]        third_value;
    logic [15:0]       ident_word;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic              out_kind;
    event_t            event_code;
    logic [3:0]        packet_type;
    logic [1:0]        qos_level;
    logic [15:0]       packet_ident;
    logic [15:0]       topic_length;
    logic [LEN_W-1:0]  payload_length;
    logic [7:0]        return_code;
    logic [7:0]        ack_byte;
    logic              last;
  } result_t;

endpackage

@@ rtl/mqttd_front.sv @@
// front end: accepts bytes, tracks framing and captures body fields
module mqttd_front #(
  parameter int unsigned LENGTH_BYTES_MAX = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output mqttd_pkg::cmd_t   push_cmd,
  input  logic              q_full
);
  import mqttd_pkg::*;

  localparam logic [2:0] LEN_MAX = 3'(LENGTH_BYTES_MAX);

  phase_t            phase, phase_next;
  logic [7:0]        header, header_next;
  logic [LEN_W-1:0]  rem_len, rem_len_next;
  logic [2:0]        len_count, len_count_next;
  logic [LEN_W-1:0]  pos, pos_next;
  logic [15:0]       first_word, first_word_next;
  logic [7:0]        third_value, third_value_next;
  logic [15:0]       ident_word, ident_word_next;

  logic              accept;
  logic [LEN_W-1:0]  len_group;
  logic [LEN_W-1:0]  len_merged;
  logic [2:0]        count_inc;
  logic              too_long;
  logic              len_done;
  logic              len_zero;
  logic [LEN_W-1:0]  pos_inc;
  logic              body_done;
  logic [16:0]       ident_at;
  logic [16:0]       ident_at1;
  logic              pub_with_id;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // length decode, seven bits a byte, low group first
  always_comb begin
    len_group = {{(LEN_W-7){1'b0}}, in_byte[6:0]};
    unique case (len_count[1:0])
      2'd0: len_merged = rem_len | len_group;
      2'd1: len_merged = rem_len | (len_group << 7);
      2'd2: len_merged = rem_len | (len_group << 14);
      2'd3: len_merged = rem_len | (len_group << 21);
      default: len_merged = rem_len;
    endcase
    count_inc = len_count + 3'd1;
    too_long  = in_byte[7] && (count_inc >= LEN_MAX);
    len_done  = !in_byte[7];
    len_zero  = (len_merged == '0);
  end

  // body position tracking
  assign pos_inc     = pos + LEN_W'(1);
  assign body_done   = (pos_inc == rem_len);
  assign ident_at    = 17'd2 + {1'b0, first_word};
  assign ident_at1   = ident_at + 17'd1;
  assign pub_with_id = (header[7:4] == PT_PUBLISH) &&
                       ((header[2:1] == 2'd1) || (header[2:1] == 2'd2)) &&
                       (pos >= LEN_W'(2));

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_LENGTH: begin
          if (too_long) begin
            phase_next = PH_HEADER;
          end else if (len_done) begin
            phase_next = len_zero ? PH_HEADER : PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_done) begin
            phase_next = PH_HEADER;
          end
        end
        default: begin
          phase_next = PH_LENGTH;
        end
      endcase
    end
  end

  // datapath updates and completion push
  always_comb begin
    header_next      = header;
    rem_len_next     = rem_len;
    len_count_next   = len_count;
    pos_next         = pos;
    first_word_next  = first_word;
    third_value_next = third_value;
    ident_word_next  = ident_word;
    push             = 1'b0;
    if (accept) begin
      unique case (phase)
        PH_LENGTH: begin
          rem_len_next   = len_merged;
          len_count_next = count_inc;
          push           = too_long || (len_done && len_zero);
        end
        PH_BODY: begin
          if (pos == '0) begin
            first_word_next = {in_byte, first_word[7:0]};
          end else if (pos == LEN_W'(1)) begin
            first_word_next = {first_word[15:8], in_byte};
          end else if (pos == LEN_W'(2)) begin
            third_value_next = in_byte;
          end
          if (pub_with_id) begin
            if (pos == LEN_W'(ident_at)) begin
              ident_word_next = {in_byte, ident_word[7:0]};
            end else if (pos == LEN_W'(ident_at1)) begin
              ident_word_next = {ident_word[15:8], in_byte};
            end
          end
          pos_next = pos_inc;
          push     = body_done;
        end
        default: begin
          header_next      = in_byte;
          rem_len_next     = '0;
          len_count_next   = '0;
          pos_next         = '0;
          first_word_next  = '0;
          third_value_next = '0;
          ident_word_next  = '0;
        end
      endcase
    end
    push_cmd.too_long    = (phase == PH_LENGTH) && too_long;
    push_cmd.header      = header;
    push_cmd.rem_len     = rem_len_next;
    push_cmd.first_word  = first_word_next;
    push_cmd.third_value = third_value_next;
    push_cmd.ident_word  = ident_word_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      header      <= '0;
      rem_len     <= '0;
      len_count   <= '0;
      pos         <= '0;
      first_word  <= '0;
      third_value <= '0;
      ident_word  <= '0;
    end else begin
      phase       <= phase_next;
      header      <= header_next;
      rem_len     <= rem_len_next;
      len_count   <= len_count_next;
      pos         <= pos_next;
      first_word  <= first_word_next;
      third_value <= third_value_next;
      ident_word  <= ident_word_next;
    end
  end

endmodule

@@ rtl/mqttd_queue.sv @@
// short register queue of packet completions between front and back
module mqttd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mqttd_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output mqttd_pkg::cmd_t  head
);
  import mqttd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/mqttd_back.sv @@
// back end: turns completions into event records and reply bytes
module mqttd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  mqttd_pkg::cmd_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output mqttd_pkg::result_t out_item
);
  import mqttd_pkg::*;

  logic [2:0]   ack_left;
  logic [15:0]  ack_id;
  logic [7:0]   ack_head;
  logic         load;

  logic [3:0]   ptype;
  logic [1:0]   qos;
  logic [16:0]  need;
  logic [LEN_W:0] diff;
  logic         rl_lt2;
  logic         rl_lt3;
  result_t      ev;
  logic         ev_acks;
  result_t      ack;

  assign load = !out_valid || out_ready;
  assign pop  = load && (ack_left == '0) && q_not_empty;

  // event record from the queue head
  always_comb begin
    ptype   = head.header[7:4];
    qos     = head.header[2:1];
    need    = 17'd2 + {1'b0, head.first_word} + ((qos != 2'd0) ? 17'd2 : 17'd0);
    diff    = {1'b0, head.rem_len} - {{(LEN_W-16){1'b0}}, need};
    rl_lt2  = (head.rem_len < LEN_W'(2));
    rl_lt3  = (head.rem_len < LEN_W'(3));
    ev_acks = 1'b0;
    ev      = '0;
    ev.out_kind    = KIND_EVENT;
    ev.packet_type = ptype;
    ev.last        = 1'b1;
    if (head.too_long) begin
      ev.event_code = EV_MALFORMED;
    end else begin
      unique case (ptype)
        PT_CONNACK: begin
          if (rl_lt2) begin
            ev.event_code = EV_MALFORMED;
          end else begin
            ev.event_code  = (head.first_word[7:0] == 8'd0) ? EV_CONNECTED : EV_REFUSED;
            ev.return_code = head.first_word[7:0];
          end
        end
        PT_SUBACK: begin
          if (rl_lt3) begin
            ev.event_code = EV_MALFORMED;
          end else begin
            ev.event_code   = EV_SUBACK;
            ev.packet_ident = head.first_word;
            ev.return_code  = head.third_value;
          end
        end
        PT_UNSUBACK: begin
          if (rl_lt2) begin
            ev.event_code = EV_MALFORMED;
          end else begin
            ev.event_code   = EV_SUBACK;
            ev.packet_ident = head.first_word;
          end
        end
        PT_PUBACK: begin
          if (rl_lt2) begin
            ev.event_code = EV_MALFORMED;
          end else begin
            ev.event_code   = EV_PUBACK;
            ev.packet_ident = head.first_word;
          end
        end
        PT_PUBLISH: begin
          if ((qos == 2'd3) || diff[LEN_W]) begin
            ev.event_code = EV_MALFORMED;
          end else begin
            ev.event_code     = EV_PUBLISH;
            ev.qos_level      = qos;
            ev.packet_ident   = (qos != 2'd0) ? head.ident_word : 16'd0;
            ev.topic_length   = head.first_word;
            ev.payload_length = diff[LEN_W-1:0];
            ev_acks           = (qos != 2'd0);
            ev.last           = (qos == 2'd0);
          end
        end
        default: begin
          ev.event_code = EV_UNHANDLED;
        end
      endcase
    end
  end

  // reply byte for the current step of the acknowledgement
  always_comb begin
    ack          = '0;
    ack.out_kind = KIND_ACK;
    ack.last     = (ack_left == 3'd1);
    unique case (ack_left)
      3'd4:    ack.ack_byte = ack_head;
      3'd3:    ack.ack_byte = ACK_LEN_BYTE;
      3'd2:    ack.ack_byte = ack_id[15:8];
      default: ack.ack_byte = ack_id[7:0];
    endcase
  end

  // output register and reply sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ack_left  <= '0;
    end else if (load) begin
      if (ack_left != '0) begin
        out_valid <= 1'b1;
        ack_left  <= ack_left - 3'd1;
      end else if (q_not_empty) begin
        out_valid <= 1'b1;
        ack_left  <= ev_acks ? 3'd4 : 3'd0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (load) begin
      if (ack_left != '0) begin
        out_item <= ack;
      end else if (q_not_empty) begin
        out_item <= ev;
        ack_id   <= head.ident_word;
        ack_head <= {(qos == 2'd1) ? PT_PUBACK : PT_PUBREC, 4'h0};
      end
    end
  end

endmodule

@@ rtl/mqtt_packet_deframer.sv @@
// top level of the mqtt packet deframer
//
//  channel  | direction | tdata                      | tuser    | tlast
//  s_*      | in        | rx_byte                    | -        | -
//  m_*      | out       | event and reply fields     | out_kind | last
//
// one byte is taken every cycle; the parser never waits on packet contents
// a finished packet goes into a QUEUE_DEPTH entry queue; while m_tready is
// high the emitter sends one result a cycle: one event record, plus four
// reply bytes for a publish with qos 1 or 2, so input stalls only while
// that queue is full; a packet is queued, then its results are registered
// synchronous reset returns the parser to waiting for a header byte
module mqtt_packet_deframer #(
  parameter int unsigned LENGTH_BYTES_MAX = 4,
  parameter int unsigned QUEUE_DEPTH      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] event_code, [6:3] packet_type, [8:7] qos_level, [24:9] packet_ident,
  // [40:25] topic_length, [68:41] payload_length, [76:69] return_code,
  // [84:77] ack_byte, [87:85] zero
  output logic [mqttd_pkg::TDATA_W-1:0] m_tdata,
  output logic [0:0]  m_tuser,   // [0] out_kind
  output logic        m_tlast
);
  import mqttd_pkg::*;

  logic     push;
  cmd_t     push_cmd;
  logic     q_full;
  logic     q_not_empty;
  logic     pop;
  cmd_t     head;
  result_t  item;

  // parser
  mqttd_front #(
    .LENGTH_BYTES_MAX (LENGTH_BYTES_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // completion queue
  mqttd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // emitter
  mqttd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_item    (item)
  );

  // output packing
  assign m_tdata = {3'b000, item.ack_byte, item.return_code, item.payload_length,
                    item.topic_length, item.packet_ident, item.qos_level,
                    item.packet_type, item.event_code};
  assign m_tuser = item.out_kind;
  assign m_tlast = item.last;

endmodule

@@ test/tb_mqtt_packet_deframer.sv @@
// self-checking testbench for the mqtt packet deframer
`timescale 1ns / 100ps

module tb_mqtt_packet_deframer;
  import mqttd_pkg::*;

  localparam int unsigned LEN_BYTES_LIMIT = 4;
  localparam int unsigned REPORT_LIMIT    = 10;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned DRAIN_CYCLES    = 20;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [TDATA_W-1:0]  m_tdata;
  logic [0:0]          m_tuser;
  logic                m_tlast;

  mqtt_packet_deframer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // shadow copy of the parser state
  phase_t      rx_phase;
  logic [7:0]  hdr_byte;
  logic [27:0] rem_len;
  logic [2:0]  len_count;
  logic [27:0] body_pos;
  logic [15:0] lead_word;
  logic [7:0]  body_byte2;
  logic [15:0] pkt_id;

  // results still owed by the block, oldest first
  result_t     pending_results[$];

  // bytes of the packet being built
  logic [7:0]  pkt_bytes[$];

  bit          src_idle_en;
  bit          rx_idle_en;
  logic        hold_req;
  int unsigned hold_left;
  int unsigned stall_left;
  int unsigned bytes_sent;
  int unsigned events_seen;
  int unsigned replies_seen;
  int unsigned error_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // packet parser prediction

  function automatic void clear_parser();
    rx_phase   = PH_HEADER;
    hdr_byte   = '0;
    rem_len    = '0;
    len_count  = '0;
    body_pos   = '0;
    lead_word  = '0;
    body_byte2 = '0;
    pkt_id     = '0;
  endfunction

  function automatic void push_event(event_t code, logic [3:0] ptype, logic [1:0] q,
                                     logic [15:0] id, logic [15:0] tlen,
                                     logic [27:0] plen, logic [7:0] rc);
    result_t r;
    r = '0;
    r.out_kind       = KIND_EVENT;
    r.event_code     = code;
    r.packet_type    = ptype;
    r.qos_level      = q;
    r.packet_ident   = id;
    r.topic_length   = tlen;
    r.payload_length = plen;
    r.return_code    = rc;
    pending_results.push_back(r);
  endfunction

  function automatic void push_reply_byte(logic [7:0] b);
    result_t r;
    r = '0;
    r.out_kind = KIND_ACK;
    r.ack_byte = b;
    pending_results.push_back(r);
  endfunction

  function automatic void mark_last();
    pending_results[pending_results.size()-1].last = 1'b1;
  endfunction

  // packet complete: one event, plus the reply for a good publish above qos 0
  function automatic void finish_packet();
    logic [3:0]  ptype;
    logic [1:0]  q;
    int unsigned need;
    ptype = hdr_byte[7:4];
    q     = hdr_byte[2:1];
    rx_phase = PH_HEADER;
    case (ptype)
      PT_CONNACK: begin
        if (rem_len < 2)
          push_event(EV_MALFORMED, ptype, 0, 0, 0, 0, 0);
        else
          push_event((lead_word[7:0] == 0) ? EV_CONNECTED : EV_REFUSED,
                     ptype, 0, 0, 0, 0, lead_word[7:0]);
      end
      PT_SUBACK: begin
        if (rem_len < 3)
          push_event(EV_MALFORMED, ptype, 0, 0, 0, 0, 0);
        else
          push_event(EV_SUBACK, ptype, 0, lead_word, 0, 0, body_byte2);
      end
      PT_UNSUBACK: begin
        if (rem_len < 2)
          push_event(EV_MALFORMED, ptype, 0, 0, 0, 0, 0);
        else
          push_event(EV_SUBACK, ptype, 0, lead_word, 0, 0, 0);
      end
      PT_PUBACK: begin
        if (rem_len < 2)
          push_event(EV_MALFORMED, ptype, 0, 0, 0, 0, 0);
        else
          push_event(EV_PUBACK, ptype, 0, lead_word, 0, 0, 0);
      end
      PT_PUBLISH: begin
        need = 2 + lead_word + ((q != 0) ? 2 : 0);
        if (q == 2'd3 || rem_len < need) begin
          push_event(EV_MALFORMED, ptype, 0, 0, 0, 0, 0);
        end else begin
          push_event(EV_PUBLISH, ptype, q, (q != 0) ? pkt_id : 16'h0, lead_word,
                     28'(rem_len - need), 0);
          if (q != 0) begin
            push_reply_byte({(q == 2'd1) ? PT_PUBACK : PT_PUBREC, 4'h0});
            push_reply_byte(ACK_LEN_BYTE);
            push_reply_byte(pkt_id[15:8]);
            push_reply_byte(pkt_id[7:0]);
          end
        end
      end
      default: begin
        push_event(EV_UNHANDLED, ptype, 0, 0, 0, 0, 0);
      end
    endcase
    mark_last();
  endfunction

  // advance the shadow parser by one accepted byte
  function automatic void predict_byte(logic [7:0] b);
    int unsigned pos;
    int unsigned at;
    case (rx_phase)
      PH_LENGTH: begin
        rem_len   = rem_len | (28'(b[6:0]) << (7 * len_count[1:0]));
        len_count = len_count + 1;
        if (b[7]) begin
          if (len_count >= LEN_BYTES_LIMIT) begin
            rx_phase = PH_HEADER;
            push_event(EV_MALFORMED, hdr_byte[7:4], 0, 0, 0, 0, 0);
            mark_last();
          end
        end else if (rem_len == 0) begin
          finish_packet();
        end else begin
          rx_phase = PH_BODY;
        end
      end
      PH_BODY: begin
        pos = body_pos;
        if (pos == 0)
          lead_word[15:8] = b;
        else if (pos == 1)
          lead_word[7:0] = b;
        else if (pos == 2)
          body_byte2 = b;
        // packet id sits right after the topic of a qos 1 or 2 publish
        if (hdr_byte[7:4] == PT_PUBLISH && (hdr_byte[2:1] == 2'd1 || hdr_byte[2:1] == 2'd2)
            && pos >= 2) begin
          at = 2 + lead_word;
          if (pos == at)
            pkt_id[15:8] = b;
          else if (pos == at + 1)
            pkt_id[7:0] = b;
        end
        body_pos = 28'(pos + 1);
        if (body_pos == rem_len)
          finish_packet();
      end
      default: begin
        hdr_byte   = b;
        rem_len    = '0;
        len_count  = '0;
        body_pos   = '0;
        lead_word  = '0;
        body_byte2 = '0;
        pkt_id     = '0;
        rx_phase   = PH_LENGTH;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // byte sender

  task automatic send_byte(logic [7:0] b);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    predict_byte(b);
    bytes_sent++;
  endtask

  task automatic send_packet();
    foreach (pkt_bytes[i])
      send_byte(pkt_bytes[i]);
    pkt_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // packet builders

  // remaining length, low group first; stretched encodings pad with zero groups
  function automatic void add_length(int unsigned rl, bit stretch);
    int unsigned groups;
    int unsigned total;
    groups = 1;
    while (groups < LEN_BYTES_LIMIT && (rl >> (7 * groups)) != 0)
      groups++;
    total = stretch ? $urandom_range(LEN_BYTES_LIMIT, groups) : groups;
    for (int i = 0; i < total; i++)
      pkt_bytes.push_back(8'((rl >> (7 * i)) & 32'h7F) | ((i < total - 1) ? 8'h80 : 8'h00));
  endfunction

  function automatic void build_publish(logic [1:0] q, int unsigned tlen, int unsigned plen);
    logic [15:0] id;
    id = 16'($urandom);
    pkt_bytes.push_back({PT_PUBLISH, 1'($urandom_range(0, 1)), q, 1'($urandom_range(0, 1))});
    add_length(2 + tlen + ((q != 0) ? 2 : 0) + plen, $urandom_range(0, 3) == 0);
    pkt_bytes.push_back(tlen[15:8]);
    pkt_bytes.push_back(tlen[7:0]);
    repeat (tlen) pkt_bytes.push_back(8'($urandom));
    if (q != 0) begin
      pkt_bytes.push_back(id[15:8]);
      pkt_bytes.push_back(id[7:0]);
    end
    repeat (plen) pkt_bytes.push_back(8'($urandom));
  endfunction

  // header of the given type with random flags and a random body
  function automatic void build_plain(logic [3:0] ptype, int unsigned rl);
    logic [7:0] b;
    pkt_bytes.push_back({ptype, 4'($urandom)});
    add_length(rl, $urandom_range(0, 3) == 0);
    for (int i = 0; i < rl; i++) begin
      b = 8'($urandom);
      if (i == 1 && ptype == PT_CONNACK && $urandom_range(0, 1) == 1)
        b = 8'h00;
      pkt_bytes.push_back(b);
    end
  endfunction

  function automatic logic [3:0] pick_reply_type();
    case ($urandom_range(0, 3))
      0:       return PT_CONNACK;
      1:       return PT_SUBACK;
      2:       return PT_UNSUBACK;
      default: return PT_PUBACK;
    endcase
  endfunction

  // mostly well formed packets, the rest faults and noise
  function automatic void build_random_packet();
    int unsigned pick;
    logic [3:0]  ptype;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      build_publish(2'($urandom_range(0, 2)), $urandom_range(0, 6), $urandom_range(120, 200));
    end else if (pick < 36) begin
      build_publish(2'($urandom_range(0, 2)), $urandom_range(0, 6), $urandom_range(0, 8));
    end else if (pick < 60) begin
      ptype = pick_reply_type();
      build_plain(ptype, ((ptype == PT_SUBACK) ? 3 : 2) + $urandom_range(0, 2));
    end else if (pick < 70) begin
      // short bodies, mostly too short for their type
      ptype = ($urandom_range(0, 4) == 0) ? PT_PUBLISH : pick_reply_type();
      build_plain(ptype, $urandom_range(0, 2));
    end else if (pick < 78) begin
      // publish with random flags and body, often qos 3 or a topic running past the body
      build_plain(PT_PUBLISH, $urandom_range(2, 8));
    end else if (pick < 86) begin
      do ptype = 4'($urandom_range(0, 15));
      while (ptype inside {PT_CONNACK, PT_PUBLISH, PT_PUBACK, PT_SUBACK, PT_UNSUBACK});
      build_plain(ptype, $urandom_range(0, 4));
    end else if (pick < 92) begin
      // length field that never ends
      pkt_bytes.push_back(8'($urandom));
      repeat (LEN_BYTES_LIMIT) pkt_bytes.push_back(8'($urandom) | 8'h80);
    end else begin
      build_plain(4'($urandom), $urandom_range(0, 20));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result receiver and checker

  function automatic string show(result_t r);
    return $sformatf("kind=%0d ev=%0d type=%h qos=%0d id=%h topic=%0d payload=%0d rc=%h ack=%h last=%0d",
                     r.out_kind, r.event_code, r.packet_type, r.qos_level, r.packet_ident,
                     r.topic_length, r.payload_length, r.return_code, r.ack_byte, r.last);
  endfunction

  function automatic void check_result();
    result_t got;
    result_t want;
    got                = '0;
    got.out_kind       = m_tuser[0];
    got.event_code     = event_t'(m_tdata[2:0]);
    got.packet_type    = m_tdata[6:3];
    got.qos_level      = m_tdata[8:7];
    got.packet_ident   = m_tdata[24:9];
    got.topic_length   = m_tdata[40:25];
    got.payload_length = m_tdata[68:41];
    got.return_code    = m_tdata[76:69];
    got.ack_byte       = m_tdata[84:77];
    got.last           = m_tlast;
    if (got.out_kind == KIND_ACK)
      replies_seen++;
    else
      events_seen++;
    if (pending_results.size() == 0) begin
      error_count++;
      if (error_count <= REPORT_LIMIT)
        $display("%0t: unexpected result %s", $realtime, show(got));
      return;
    end
    want = pending_results.pop_front();
    if (got.out_kind       !== want.out_kind       || got.event_code   !== want.event_code   ||
        got.packet_type    !== want.packet_type    || got.qos_level    !== want.qos_level    ||
        got.packet_ident   !== want.packet_ident   || got.topic_length !== want.topic_length ||
        got.payload_length !== want.payload_length || got.return_code  !== want.return_code  ||
        got.ack_byte       !== want.ack_byte       || got.last         !== want.last) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("%0t: mismatch", $realtime);
        $display("  expected %s", show(want));
        $display("  actual   %s", show(got));
      end
    end
  endfunction

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (rst)
      hold_left <= 0;
    else if (hold_req)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  // accept and check results, with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready)
        check_result();
      if (hold_left != 0 || stall_left != 0) begin
        m_tready <= 1'b0;
        if (stall_left != 0)
          stall_left <= stall_left - 1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready   <= 1'b0;
        stall_left <= $urandom_range(0, 15);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  // every event kind of the reply packets, plus unhandled zero length types
  task automatic test_event_types();
    pkt_bytes = {8'h20, 8'h02, 8'h00, 8'h00,          // connected
                 8'h20, 8'h02, 8'h00, 8'hFF,          // refused
                 8'h90, 8'h03, 8'hFF, 8'hFF, 8'h80,   // suback
                 8'hB0, 8'h02, 8'h00, 8'h01,          // unsuback
                 8'h40, 8'h02, 8'h12, 8'h34,          // puback
                 8'hF0, 8'h00,                        // unhandled, empty
                 8'h00, 8'h00};
    send_packet();
  endtask

  // publish with each qos, and the malformed cases
  task automatic test_publish_and_faults();
    pkt_bytes = {8'h32, 8'h05, 8'h00, 8'h01, 8'h41, 8'hAB, 8'hCD,
                 // qos 2 with a four byte length field
                 8'h3D, 8'h85, 8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h7E,
                 8'h36, 8'h02, 8'h00, 8'h00,          // qos 3
                 8'h30, 8'h01, 8'h00,                 // body shorter than topic field
                 8'h20, 8'h01, 8'h55,                 // short connack
                 8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF,   // length too long
                 8'hC0, 8'h80, 8'h80, 8'h80, 8'h00};  // zero length after four bytes
    send_packet();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < 80) begin
      build_random_packet();
      send_packet();
    end
  endtask

  // receiver stops while publishes keep coming, so the input must stall
  task automatic test_output_backpressure();
    s_tvalid <= 1'b0;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (10) begin
      build_publish(2'($urandom_range(1, 2)), $urandom_range(0, 2), $urandom_range(0, 2));
      send_packet();
    end
  endtask

  task automatic test_steady_stream();
    src_idle_en = 1'b0;
    rx_idle_en <= 1'b0;
    repeat (5) begin
      build_random_packet();
      send_packet();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence

  initial begin
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= 8'h00;
    hold_req     <= 1'b0;
    src_idle_en  = 1'b1;
    rx_idle_en   = 1'b1;
    bytes_sent   = 0;
    events_seen  = 0;
    replies_seen = 0;
    error_count  = 0;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_event_types();
    test_publish_and_faults();
    test_random_traffic();
    test_output_backpressure();
    test_steady_stream();
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes; checked %0d event records and %0d reply bytes",
             bytes_sent, events_seen, replies_seen);
    $display("mismatches or stray results: %0d", error_count);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
